/* design/assert_macros.svh */
// ----------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compensation checker.
// ----------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define BPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, also while reset is held.
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bpc_pkg.sv */
// ----------------------------------------------------------------
// Compensation package
// Widths, constants and shared types of the compensation block.
// ----------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int RawW     = 20;
    localparam int TempW    = 15;
    localparam int PressW   = 32;
    localparam int CfgW     = 64;
    localparam int CfgIdxW  = 3;
    localparam int DivSteps = 64;
    localparam int P4Shift  = 35;

    localparam logic signed [TempW-1:0] TempMin = -15'sd4000;
    localparam logic signed [TempW-1:0] TempMax = 15'sd8500;
    localparam logic signed [31:0] TempMin32    = -32'sd4000;
    localparam logic signed [31:0] TempMax32    = 32'sd8500;
    localparam logic signed [31:0] TempRound    = 32'sd128;
    localparam logic signed [23:0] FineOffset   = 24'sd128000;
    localparam logic [11:0] PressScale          = 12'd3125;
    localparam logic [20:0] PressBase           = 21'd1048576;
    localparam logic [63:0] ZBias               = 64'd1 << 47;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_T1  = 3'd0,
        CFG_T2  = 3'd1,
        CFG_T3  = 3'd2,
        CFG_P1  = 3'd3,
        CFG_P25 = 3'd4,
        CFG_P69 = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } cfg_t;

    typedef struct packed {
        logic [TempW-1:0] temp;
        logic             sat;
        logic [RawW-1:0]  ap;
    } side_t;

endpackage

`default_nettype wire

/* design/bpc_if.sv */
// ----------------------------------------------------------------
// Compensation stream interfaces
// Valid/ready channels for the raw reading pairs and the results.
// ----------------------------------------------------------------
`default_nettype none

interface bpc_in_if
    import bpc_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if
    import bpc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [TempW-1:0]  temperature_centi;
    logic [PressW-1:0]        pressure_q24_8;
    logic                     temp_saturated;
    logic                     divisor_zero;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output temp_saturated, output divisor_zero, input ready);
    modport sink (input valid, input temperature_centi, input pressure_q24_8,
                  input temp_saturated, input divisor_zero, output ready);
endinterface

`default_nettype wire

/* design/bpc_temp.sv */
// ----------------------------------------------------------------
// Temperature pipeline
// Five stages that form the fine temperature term, the clamped
// temperature and the offset term that starts the pressure path.
// ----------------------------------------------------------------
`default_nettype none

module bpc_temp
    import bpc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire logic [RawW-1:0] raw_t,
    input  wire logic [RawW-1:0] raw_p,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output logic signed [23:0]   x_out,
    output side_t                side_out
);

    localparam int N = 5;

    logic [N-1:0] v_reg;
    logic [N-1:0] ce;

    logic signed [17:0] d1_reg, d1_next;
    logic signed [16:0] d2_reg, d2_next;
    logic signed [33:0] m1_full, m2_full;
    logic signed [31:0] m1_reg, m2_reg;
    logic signed [31:0] s2, v1_next, v1_reg;
    logic signed [47:0] m3_full;
    logic signed [31:0] m3_reg, v2, fine_next, fine_reg;
    logic signed [31:0] tc_pre, tc;
    logic signed [31:0] tc_clamped;
    logic               sat_next;
    logic signed [23:0] x_next, x_reg;
    logic [RawW-1:0]    ap_reg [N-1];
    side_t              side_reg, side_next;

    always_comb
    begin
        ce[N-1] = !v_reg[N-1] || dn_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            ce[k] = !v_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (ce[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        d1_next  = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cfg.t1, 1'b0});
        d2_next  = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cfg.t1});
        m1_full  = d1_reg * $signed(cfg.t2);
        m2_full  = d2_reg * d2_reg;
        v1_next  = m1_reg >>> 11;
        s2       = m2_reg >>> 12;
        m3_full  = s2 * $signed(cfg.t3);
        v2       = m3_reg >>> 14;
        fine_next = v1_reg + v2;
        tc_pre   = (fine_reg <<< 2) + fine_reg + TempRound;
        tc       = tc_pre >>> 8;
        sat_next = 1'b0;
        tc_clamped = tc;
        if (tc < TempMin32)
        begin
            tc_clamped = TempMin32;
            sat_next   = 1'b1;
        end
        if (tc > TempMax32)
        begin
            tc_clamped = TempMax32;
            sat_next   = 1'b1;
        end
        x_next = fine_reg[23:0] - FineOffset;
        side_next.temp = tc_clamped[TempW-1:0];
        side_next.sat  = sat_next;
        side_next.ap   = ap_reg[N-2];
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            ap_reg[0] <= raw_p;
        end
        if (ce[1])
        begin
            m1_reg    <= m1_full[31:0];
            m2_reg    <= m2_full[31:0];
            ap_reg[1] <= ap_reg[0];
        end
        if (ce[2])
        begin
            v1_reg    <= v1_next;
            m3_reg    <= m3_full[31:0];
            ap_reg[2] <= ap_reg[1];
        end
        if (ce[3])
        begin
            fine_reg  <= fine_next;
            ap_reg[3] <= ap_reg[2];
        end
        if (ce[4])
        begin
            x_reg    <= x_next;
            side_reg <= side_next;
        end
    end

    assign up_ready = ce[0];
    assign dn_valid = v_reg[N-1];
    assign x_out    = x_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

/* design/bpc_pcoef.sv */
// ----------------------------------------------------------------
// Pressure term pipeline
// Seven stages that form the dividend and the divisor of the
// pressure division and their signs and magnitudes.
// ----------------------------------------------------------------
`default_nettype none

module bpc_pcoef
    import bpc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire logic signed [23:0] x_in,
    input  wire side_t         side_in,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output logic [63:0]        ma_out,
    output logic [31:0]        mb_out,
    output logic               neg_out,
    output logic               dz_out,
    output side_t              side_out
);

    localparam int N = 7;

    logic [N-1:0] v_reg;
    logic [N-1:0] ce;
    side_t        side_reg [N];

    logic signed [47:0] xx_next, xx_reg;
    logic signed [39:0] xp5_next, xp5_reg [2];
    logic signed [39:0] xp2_next, xp2_reg [2];
    logic signed [63:0] ya_next, ya_reg, za_next, za_reg, za_sh;
    logic [63:0]        y_next, y_reg, z_next, z_reg;
    logic [63:0]        w_next, w_reg, num0_next, num0_reg;
    logic [20:0]        pp;
    logic [47:0]        pl_next, pl_reg;
    logic [31:0]        ph_next, ph_reg;
    logic [43:0]        nl_next, nl_reg;
    logic [31:0]        nh_next, nh_reg;
    logic [63:0]        zz_next, zz_reg, num_next, num_reg;
    logic [30:0]        zs;
    logic [63:0]        ma_next, ma_reg;
    logic [31:0]        mb_next, mb_reg;
    logic               neg_next, neg_reg, dz_next, dz_reg;

    always_comb
    begin
        ce[N-1] = !v_reg[N-1] || dn_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            ce[k] = !v_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (ce[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        xx_next  = x_in * x_in;
        xp5_next = x_in * $signed(cfg.p5);
        xp2_next = x_in * $signed(cfg.p2);
        ya_next  = xx_reg * $signed(cfg.p6);
        za_next  = xx_reg * $signed(cfg.p3);
        za_sh    = za_reg >>> 8;
        y_next   = ya_reg + ({{24{xp5_reg[1][39]}}, xp5_reg[1]} << 17)
                 + ({{48{cfg.p4[15]}}, cfg.p4} << P4Shift);
        z_next   = za_sh + ({{24{xp2_reg[1][39]}}, xp2_reg[1]} << 12);
        pp        = PressBase - {1'b0, side_reg[2].ap};
        w_next    = ZBias + z_reg;
        num0_next = ({43'd0, pp} << 31) - y_reg;
        pl_next  = w_reg[31:0] * cfg.p1;
        ph_next  = w_reg[63:32] * {16'd0, cfg.p1};
        nl_next  = num0_reg[31:0] * PressScale;
        nh_next  = num0_reg[63:32] * {20'd0, PressScale};
        zz_next  = {16'd0, pl_reg} + {ph_reg, 32'd0};
        num_next = {20'd0, nl_reg} + {nh_reg, 32'd0};
        zs       = zz_reg[63:33];
        dz_next  = (zs == 31'd0);
        mb_next  = zs[30] ? (32'd0 - {zs[30], zs}) : {1'b0, zs};
        ma_next  = num_reg[63] ? (64'd0 - num_reg) : num_reg;
        neg_next = num_reg[63] ^ zs[30];
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            xx_reg     <= xx_next;
            xp5_reg[0] <= xp5_next;
            xp2_reg[0] <= xp2_next;
            side_reg[0] <= side_in;
        end
        if (ce[1])
        begin
            ya_reg     <= ya_next;
            za_reg     <= za_next;
            xp5_reg[1] <= xp5_reg[0];
            xp2_reg[1] <= xp2_reg[0];
        end
        if (ce[2])
        begin
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (ce[3])
        begin
            w_reg    <= w_next;
            num0_reg <= num0_next;
        end
        if (ce[4])
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            nl_reg <= nl_next;
            nh_reg <= nh_next;
        end
        if (ce[5])
        begin
            zz_reg  <= zz_next;
            num_reg <= num_next;
        end
        if (ce[6])
        begin
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
            neg_reg <= neg_next;
            dz_reg  <= dz_next;
        end
        for (int k = 1; k < N; k++)
        begin
            if (ce[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign up_ready = ce[0];
    assign dn_valid = v_reg[N-1];
    assign ma_out   = ma_reg;
    assign mb_out   = mb_reg;
    assign neg_out  = neg_reg;
    assign dz_out   = dz_reg;
    assign side_out = side_reg[N-1];

endmodule

`default_nettype wire

/* design/bpc_div.sv */
// ----------------------------------------------------------------
// Pipelined divider
// Restoring division of the dividend magnitude by the divisor
// magnitude, one quotient bit per stage.
// ----------------------------------------------------------------
`default_nettype none

module bpc_div
    import bpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire logic [63:0] ma_in,
    input  wire logic [31:0] mb_in,
    input  wire logic        neg_in,
    input  wire logic        dz_in,
    input  wire side_t       side_in,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output logic [63:0]      q_out,
    output logic             neg_out,
    output logic             dz_out,
    output side_t            side_out
);

    logic [DivSteps-1:0] v_reg;
    logic [DivSteps-1:0] ce;

    logic [31:0] rem_reg [DivSteps];
    logic [63:0] dq_reg  [DivSteps];
    logic [31:0] mb_reg  [DivSteps];
    logic        neg_reg [DivSteps];
    logic        dz_reg  [DivSteps];
    side_t       side_reg [DivSteps];

    logic [31:0] rem_in [DivSteps];
    logic [63:0] dq_in  [DivSteps];
    logic [31:0] mb_in_s [DivSteps];
    logic [31:0] rem_next [DivSteps];
    logic [63:0] dq_next  [DivSteps];

    always_comb
    begin
        ce[DivSteps-1] = !v_reg[DivSteps-1] || dn_ready;
        for (int k = DivSteps - 2; k >= 0; k--)
        begin
            ce[k] = !v_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < DivSteps; k++)
            begin
                if (ce[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic [32:0] r;
        logic [33:0] diff;
        rem_in[0]  = '0;
        dq_in[0]   = ma_in;
        mb_in_s[0] = mb_in;
        for (int k = 1; k < DivSteps; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            dq_in[k]   = dq_reg[k-1];
            mb_in_s[k] = mb_reg[k-1];
        end
        for (int k = 0; k < DivSteps; k++)
        begin
            r    = {rem_in[k], dq_in[k][63]};
            diff = {1'b0, r} - {2'b00, mb_in_s[k]};
            if (!diff[33])
            begin
                rem_next[k] = diff[31:0];
            end
            else
            begin
                rem_next[k] = r[31:0];
            end
            dq_next[k] = {dq_in[k][62:0], !diff[33]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            neg_reg[0]  <= neg_in;
            dz_reg[0]   <= dz_in;
            side_reg[0] <= side_in;
        end
        for (int k = 0; k < DivSteps; k++)
        begin
            if (ce[k])
            begin
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
                mb_reg[k]  <= mb_in_s[k];
            end
        end
        for (int k = 1; k < DivSteps; k++)
        begin
            if (ce[k])
            begin
                neg_reg[k]  <= neg_reg[k-1];
                dz_reg[k]   <= dz_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign up_ready = ce[0];
    assign dn_valid = v_reg[DivSteps-1];
    assign q_out    = dq_reg[DivSteps-1];
    assign neg_out  = neg_reg[DivSteps-1];
    assign dz_out   = dz_reg[DivSteps-1];
    assign side_out = side_reg[DivSteps-1];

endmodule

`default_nettype wire

/* design/bpc_pfin.sv */
// ----------------------------------------------------------------
// Pressure finishing pipeline
// Seven stages that apply the quotient sign and the second-order
// pressure correction and cut the result to 32 bits.
// ----------------------------------------------------------------
`default_nettype none

module bpc_pfin
    import bpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire logic [63:0] q_in,
    input  wire logic        neg_in,
    input  wire logic        dz_in,
    input  wire side_t       side_in,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output logic [PressW-1:0] press_out,
    output logic             dz_out,
    output side_t            side_out
);

    localparam int N = 7;

    logic [N-1:0] v_reg;
    logic [N-1:0] ce;
    side_t        side_reg [N];
    logic         dz_reg   [N];
    logic [63:0]  p_reg    [N-2];

    logic [63:0]        p_next;
    logic signed [63:0] a_s;
    logic [63:0]        sq_lo_next, sq_lo_reg;
    logic [31:0]        sq_x_next, sq_x_reg;
    logic signed [48:0] p8l_next, p8l_reg;
    logic [31:0]        p8h_next, p8h_reg;
    logic [63:0]        aa_next, aa_reg;
    logic signed [63:0] p8p_next, p8p_reg [2];
    logic signed [48:0] l9_next, l9_reg;
    logic [31:0]        h9_next, h9_reg;
    logic signed [63:0] pa, xv_next, xv_reg, yv_next, yv_reg;
    logic signed [63:0] s_next, s_reg, s_sh;
    logic [63:0]        r;
    logic [PressW-1:0]  press_next, press_reg;

    always_comb
    begin
        ce[N-1] = !v_reg[N-1] || dn_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            ce[k] = !v_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (ce[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        p_next     = neg_in ? (64'd0 - q_in) : q_in;
        a_s        = $signed(p_reg[0]) >>> 13;
        sq_lo_next = a_s[31:0] * a_s[31:0];
        sq_x_next  = a_s[31:0] * a_s[63:32];
        p8l_next   = $signed({1'b0, p_reg[0][31:0]}) * $signed(cfg.p8);
        p8h_next   = p_reg[0][63:32] * {{16{cfg.p8[15]}}, cfg.p8};
        aa_next    = sq_lo_reg + {sq_x_reg[30:0], 33'd0};
        p8p_next   = {{15{p8l_reg[48]}}, p8l_reg} + {p8h_reg, 32'd0};
        l9_next    = $signed({1'b0, aa_reg[31:0]}) * $signed(cfg.p9);
        h9_next    = aa_reg[63:32] * {{16{cfg.p9[15]}}, cfg.p9};
        pa         = {{15{l9_reg[48]}}, l9_reg} + {h9_reg, 32'd0};
        xv_next    = pa >>> 25;
        yv_next    = p8p_reg[1] >>> 19;
        s_next     = $signed(p_reg[4]) + xv_reg + yv_reg;
        s_sh       = s_reg >>> 8;
        r          = s_sh + ({{48{cfg.p7[15]}}, cfg.p7} << 4);
        press_next = dz_reg[5] ? '0 : r[PressW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            p_reg[0]    <= p_next;
            dz_reg[0]   <= dz_in;
            side_reg[0] <= side_in;
        end
        if (ce[1])
        begin
            sq_lo_reg <= sq_lo_next;
            sq_x_reg  <= sq_x_next;
            p8l_reg   <= p8l_next;
            p8h_reg   <= p8h_next;
        end
        if (ce[2])
        begin
            aa_reg     <= aa_next;
            p8p_reg[0] <= p8p_next;
        end
        if (ce[3])
        begin
            l9_reg     <= l9_next;
            h9_reg     <= h9_next;
            p8p_reg[1] <= p8p_reg[0];
        end
        if (ce[4])
        begin
            xv_reg <= xv_next;
            yv_reg <= yv_next;
        end
        if (ce[5])
        begin
            s_reg <= s_next;
        end
        if (ce[6])
        begin
            press_reg <= press_next;
        end
        for (int k = 1; k < N - 2; k++)
        begin
            if (ce[k])
            begin
                p_reg[k] <= p_reg[k-1];
            end
        end
        for (int k = 1; k < N; k++)
        begin
            if (ce[k])
            begin
                dz_reg[k]   <= dz_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign up_ready  = ce[0];
    assign dn_valid  = v_reg[N-1];
    assign press_out = press_reg;
    assign dz_out    = dz_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

`default_nettype wire

/* design/baro_temp_press_compensation.sv */
// ----------------------------------------------------------------
// Barometric temperature and pressure compensation
// Integer compensation of raw temperature and pressure readings
// with twelve calibration coefficients held in write-only registers.
// ----------------------------------------------------------------
//
//  Channel  Direction  Contents
//  -------  ---------  ------------------------------------------------
//  sample   in         raw_temperature, raw_pressure
//  result   out        temperature_centi, pressure_q24_8, flags
//  cfg_*    in         write enable, register index, 64-bit write data
//
//  One word is taken per clock unless the result channel stalls; its
//  result passes through every stage in turn into the result register.
//  The 84 register stages: the 64-stage divider, arithmetic and result stages.
//  Every stage holds its own valid bit, so an empty stage fills even while
//  the result register is stalled; words are never dropped or repeated.
//  Reset clears all valid bits and loads the default coefficients.
//
`default_nettype none

module baro_temp_press_compensation
    import bpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    bpc_in_if.sink                  sample,
    bpc_out_if.source               result,
    input  wire logic               cfg_write,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [CfgW-1:0]    cfg_data
);

    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [63:0] p25_reg, p69_reg;
    cfg_t        cfg;

    logic               t_valid, t_ready;
    logic signed [23:0] t_x;
    side_t              t_side;
    logic               c_valid, c_ready;
    logic [63:0]        c_ma;
    logic [31:0]        c_mb;
    logic               c_neg, c_dz;
    side_t              c_side;
    logic               d_valid, d_ready;
    logic [63:0]        d_q;
    logic               d_neg, d_dz;
    side_t              d_side;
    logic               f_valid, f_ready;
    logic [PressW-1:0]  f_press;
    logic               f_dz;
    side_t              f_side;

    logic               out_v_reg;
    logic [TempW-1:0]   out_temp_reg;
    logic [PressW-1:0]  out_press_reg;
    logic               out_sat_reg, out_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= 16'd27504;
            t2_reg  <= 16'd26435;
            t3_reg  <= 16'hFC18;
            p1_reg  <= 16'd36477;
            p25_reg <= 64'd39418759069357635;
            p69_reg <= 64'd1689068629733998585;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_T1:  t1_reg  <= cfg_data[15:0];
                CFG_T2:  t2_reg  <= cfg_data[15:0];
                CFG_T3:  t3_reg  <= cfg_data[15:0];
                CFG_P1:  p1_reg  <= cfg_data[15:0];
                CFG_P25: p25_reg <= cfg_data;
                CFG_P69: p69_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.t1 = t1_reg;
        cfg.t2 = t2_reg;
        cfg.t3 = t3_reg;
        cfg.p1 = p1_reg;
        cfg.p2 = p25_reg[15:0];
        cfg.p3 = p25_reg[31:16];
        cfg.p4 = p25_reg[47:32];
        cfg.p5 = p25_reg[63:48];
        cfg.p6 = p69_reg[15:0];
        cfg.p7 = p69_reg[31:16];
        cfg.p8 = p69_reg[47:32];
        cfg.p9 = p69_reg[63:48];
    end

    bpc_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (sample.valid),
        .up_ready (sample.ready),
        .raw_t    (sample.raw_temperature),
        .raw_p    (sample.raw_pressure),
        .dn_valid (t_valid),
        .dn_ready (t_ready),
        .x_out    (t_x),
        .side_out (t_side)
    );

    bpc_pcoef u_pcoef (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (t_valid),
        .up_ready (t_ready),
        .x_in     (t_x),
        .side_in  (t_side),
        .dn_valid (c_valid),
        .dn_ready (c_ready),
        .ma_out   (c_ma),
        .mb_out   (c_mb),
        .neg_out  (c_neg),
        .dz_out   (c_dz),
        .side_out (c_side)
    );

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (c_valid),
        .up_ready (c_ready),
        .ma_in    (c_ma),
        .mb_in    (c_mb),
        .neg_in   (c_neg),
        .dz_in    (c_dz),
        .side_in  (c_side),
        .dn_valid (d_valid),
        .dn_ready (d_ready),
        .q_out    (d_q),
        .neg_out  (d_neg),
        .dz_out   (d_dz),
        .side_out (d_side)
    );

    bpc_pfin u_pfin (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (d_valid),
        .up_ready  (d_ready),
        .q_in      (d_q),
        .neg_in    (d_neg),
        .dz_in     (d_dz),
        .side_in   (d_side),
        .dn_valid  (f_valid),
        .dn_ready  (f_ready),
        .press_out (f_press),
        .dz_out    (f_dz),
        .side_out  (f_side)
    );

    assign f_ready = !out_v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (f_ready)
        begin
            out_v_reg <= f_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_ready)
        begin
            out_temp_reg  <= f_side.temp;
            out_sat_reg   <= f_side.sat;
            out_press_reg <= f_press;
            out_dz_reg    <= f_dz;
        end
    end

    assign result.valid             = out_v_reg;
    assign result.temperature_centi = $signed(out_temp_reg);
    assign result.pressure_q24_8    = out_press_reg;
    assign result.temp_saturated    = out_sat_reg;
    assign result.divisor_zero      = out_dz_reg;

endmodule

`default_nettype wire

/* design/bpc_checker.sv */
// ----------------------------------------------------------------
// Compensation port checker
// Checks the result channel of the compensation block over time.
// ----------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpc_checker
    import bpc_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    res_valid,
    input wire logic                    res_ready,
    input wire logic signed [TempW-1:0] res_temp,
    input wire logic [PressW-1:0]       res_press,
    input wire logic                    res_sat,
    input wire logic                    res_dz
);

    `BPC_ASSERT(a_hold, res_valid && !res_ready |=> res_valid, "result word dropped while stalled")
    `BPC_ASSERT(a_dz_zero, res_valid && res_dz |-> res_press == '0, "zero divisor with nonzero pressure")
    `BPC_ASSERT(a_temp_range, res_valid |-> res_temp >= TempMin && res_temp <= TempMax, "temperature out of range")
    `BPC_ASSERT(a_sat_edge, res_valid && res_sat |-> res_temp == TempMin || res_temp == TempMax, "saturated temperature not at a limit")
    `BPC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !res_valid || rst_n, "result valid during reset")

endmodule

bind baro_temp_press_compensation bpc_checker u_bpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_temp  (result.temperature_centi),
    .res_press (result.pressure_q24_8),
    .res_sat   (result.temp_saturated),
    .res_dz    (result.divisor_zero)
);

`default_nettype wire

/* tb/baro_temp_press_compensation_tb.sv */
// ----------------------------------------------------------------
// Compensation block testbench
// Drives raw reading pairs through the compensation block with random
// idling on both channels and under several coefficient settings, and
// checks every result word against a bit-accurate integer predictor.
// ----------------------------------------------------------------
`default_nettype none

module baro_temp_press_compensation_tb;
    import bpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 100;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

    typedef struct {
        logic signed [TempW-1:0] temp;
        logic [PressW-1:0]       press;
        logic                    sat;
        logic                    dz;
    } comp_word_t;

    class comp_scoreboard;
        logic [15:0] t1, t2, t3, p1;
        logic [63:0] p25, p69;
        comp_word_t  pending[$];
        int          errors;
        int          words_in;
        int          words_out;
        int          sat_seen;
        int          dz_seen;

        function new();
            t1 = 16'd27504;
            t2 = 16'd26435;
            t3 = 16'hFC18;
            p1 = 16'd36477;
            p25 = 64'd39418759069357635;
            p69 = 64'd1689068629733998585;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [63:0] value);
            case (idx)
                CFG_T1:  t1 = value[15:0];
                CFG_T2:  t2 = value[15:0];
                CFG_T3:  t3 = value[15:0];
                CFG_P1:  p1 = value[15:0];
                CFG_P25: p25 = value;
                CFG_P69: p69 = value;
                default: ;
            endcase
        endfunction

        function logic [63:0] sx16(logic [15:0] v);
            return {{48{v[15]}}, v};
        endfunction

        function comp_word_t compensate(logic [RawW-1:0] at, logic [RawW-1:0] ap);
            logic [31:0] d, v1, v2, m, fine, tc, t2w, t3w;
            logic [63:0] x, y, z, p, q, ma, mb, c2, c3, c4, c5, c6, c7, c8, c9, ps;
            logic signed [31:0] ts;
            comp_word_t r;
            t2w = {{16{t2[15]}}, t2};
            t3w = {{16{t3[15]}}, t3};
            d = {12'd0, at} >> 3;
            d = d - ({16'd0, t1} << 1);
            m = d * t2w;
            v1 = $signed(m) >>> 11;
            d = ({12'd0, at} >> 4) - {16'd0, t1};
            m = d * d;
            m = $signed(m) >>> 12;
            m = m * t3w;
            v2 = $signed(m) >>> 14;
            fine = v1 + v2;
            m = fine * 32'd5 + 32'd128;
            tc = $signed(m) >>> 8;
            ts = $signed(tc);
            r.sat = 1'b0;
            if (ts < -32'sd4000) begin
                ts = -32'sd4000;
                r.sat = 1'b1;
            end
            if (ts > 32'sd8500) begin
                ts = 32'sd8500;
                r.sat = 1'b1;
            end
            r.temp = ts[TempW-1:0];
            c2 = sx16(p25[15:0]);
            c3 = sx16(p25[31:16]);
            c4 = sx16(p25[47:32]);
            c5 = sx16(p25[63:48]);
            c6 = sx16(p69[15:0]);
            c7 = sx16(p69[31:16]);
            c8 = sx16(p69[47:32]);
            c9 = sx16(p69[63:48]);
            x = {{32{fine[31]}}, fine} - 64'd128000;
            y = x * x * c6;
            y = y + ((x * c5) << 17);
            y = y + (c4 << 35);
            q = x * x * c3;
            z = $signed(q) >>> 8;
            z = z + ((x * c2) << 12);
            q = ((64'd1 << 47) + z) * {48'd0, p1};
            z = $signed(q) >>> 33;
            if (z == 64'd0) begin
                r.dz = 1'b1;
                p = 64'd0;
            end else begin
                r.dz = 1'b0;
                p = 64'd1048576 - {44'd0, ap};
                q = ((p << 31) - y) * 64'd3125;
                ma = q[63] ? 64'd0 - q : q;
                mb = z[63] ? 64'd0 - z : z;
                p = ma / mb;
                if (q[63] != z[63])
                    p = 64'd0 - p;
                ps = $signed(p) >>> 13;
                q = c9 * ps * ps;
                x = $signed(q) >>> 25;
                q = c8 * p;
                y = $signed(q) >>> 19;
                q = p + x + y;
                p = $signed(q) >>> 8;
                p = p + (c7 << 4);
            end
            r.press = p[31:0];
            return r;
        endfunction

        function void note_input(logic [RawW-1:0] at, logic [RawW-1:0] ap);
            pending.push_back(compensate(at, ap));
            words_in++;
        endfunction

        function void check_result(comp_word_t got);
            comp_word_t exp_w;
            words_out++;
            if (got.sat) sat_seen++;
            if (got.dz) dz_seen++;
            if (pending.size() == 0) begin
                $display("%0t: result word with nothing expected: temp %0d press %h",
                         $realtime, got.temp, got.press);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.temp !== exp_w.temp) begin
                $display("%0t: temperature_centi expected %0d actual %0d",
                         $realtime, exp_w.temp, got.temp);
                errors++;
            end
            if (got.press !== exp_w.press) begin
                $display("%0t: pressure_q24_8 expected %h actual %h",
                         $realtime, exp_w.press, got.press);
                errors++;
            end
            if (got.sat !== exp_w.sat) begin
                $display("%0t: temp_saturated expected %b actual %b",
                         $realtime, exp_w.sat, got.sat);
                errors++;
            end
            if (got.dz !== exp_w.dz) begin
                $display("%0t: divisor_zero expected %b actual %b",
                         $realtime, exp_w.dz, got.dz);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0] cfg_data = '0;

    bpc_in_if  sample_ch();
    bpc_out_if result_ch();

    comp_scoreboard sb = new();
    int  cycle_count = 0;
    int  hold_len = 0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  phases = 0;

    always #1 clk = ~clk;

    baro_temp_press_compensation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Run timed out after %0d cycles.", cycle_count);
            $display("baro_temp_press_compensation: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        comp_word_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.temp = result_ch.temperature_centi;
            got.press = result_ch.pressure_q24_8;
            got.sat = result_ch.temp_saturated;
            got.dz = result_ch.divisor_zero;
            sb.check_result(got);
        end
        if (hold_seq != hold_seen)
        begin
            hold_left = hold_len;
            hold_seen = hold_seq;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(8, 80);
        end
        else
            rx_mode_left = rx_mode_left - 1;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= 1'($urandom_range(0, 1));
                2: result_ch.ready <= ($urandom_range(0, 7) == 0);
                default: result_ch.ready <= (cycle_count % 3 != 0);
            endcase
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(cfg_idx_t'(idx), value);
    endtask

    task automatic end_writes();
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(logic [RawW-1:0] at, logic [RawW-1:0] ap);
        sample_ch.valid <= 1'b1;
        sample_ch.raw_temperature <= at;
        sample_ch.raw_pressure <= ap;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_input(at, ap);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [RawW-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RawW'($urandom_range(0, 15));
            default: return RawW'($urandom());
        endcase
    endfunction

    task automatic random_words(int count, int realistic);
        int sent;
        int burst;
        int gap;
        logic [RawW-1:0] at, ap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < count)
            begin
                if (realistic && $urandom_range(0, 3) != 0)
                begin
                    at = RawW'($urandom_range(380000, 620000));
                    ap = RawW'($urandom_range(200000, 500000));
                end
                else
                begin
                    at = pick_raw();
                    ap = pick_raw();
                end
                send_word(at, ap);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic random_coefs(int realistic);
        if (realistic)
        begin
            write_reg(CFG_T1, 64'($urandom_range(20000, 35000)));
            write_reg(CFG_T2, 64'($urandom_range(20000, 30000)));
            write_reg(CFG_T3, 64'(16'hFC18 + $urandom_range(0, 2000)));
            write_reg(CFG_P1, 64'($urandom_range(30000, 40000)));
        end
        else
        begin
            write_reg(CFG_T1, 64'($urandom()));
            write_reg(CFG_T2, 64'($urandom()));
            write_reg(CFG_T3, 64'($urandom()));
            write_reg(CFG_P1, 64'($urandom()));
        end
        write_reg(CFG_P25, {$urandom(), $urandom()});
        write_reg(CFG_P69, {$urandom(), $urandom()});
        end_writes();
        phases++;
    endtask

    initial
    begin
        logic [RawW-1:0] edge_vals[6];
        edge_vals = '{20'h00000, 20'hFFFFF, 20'h55555, 20'hAAAAA, 20'h80000, 20'h7FFFF};
        sample_ch.valid <= 1'b0;
        sample_ch.raw_temperature <= '0;
        sample_ch.raw_pressure <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_vals[i])
            send_word(edge_vals[i], edge_vals[5 - i]);
        send_word(20'd519888, 20'd415148);
        send_word(20'hFFFFF, 20'h00000);
        send_word(20'h00000, 20'hFFFFF);
        phases++;
        drain();

        // A zero first pressure coefficient forces a zero divisor.
        write_reg(CFG_P1, 64'd0);
        write_reg(CfgIdxSpareLo, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CfgIdxSpareHi, 64'd0);
        end_writes();
        send_word(20'd519888, 20'd415148);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'h00000, 20'h00000);
        phases++;
        drain();

        write_reg(CFG_T1, 64'd0);
        write_reg(CFG_T2, 64'd0);
        write_reg(CFG_T3, 64'd0);
        write_reg(CFG_P1, 64'd0);
        write_reg(CFG_P25, 64'd0);
        write_reg(CFG_P69, 64'd0);
        end_writes();
        foreach (edge_vals[i])
            send_word(edge_vals[i], edge_vals[i]);
        phases++;
        drain();

        write_reg(CFG_T1, 64'hFFFF);
        write_reg(CFG_T2, 64'h7FFF);
        write_reg(CFG_T3, 64'h8000);
        write_reg(CFG_P1, 64'hFFFF);
        write_reg(CFG_P25, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_P69, 64'h8000_7FFF_8000_7FFF);
        end_writes();
        foreach (edge_vals[i])
            send_word(edge_vals[i], edge_vals[5 - i]);
        random_words(60, 0);
        phases++;
        drain();

        write_reg(CFG_T1, 64'd27504);
        write_reg(CFG_T2, 64'd26435);
        write_reg(CFG_T3, 64'hFC18);
        write_reg(CFG_P1, 64'd36477);
        write_reg(CFG_P25, 64'd39418759069357635);
        write_reg(CFG_P69, 64'd1689068629733998585);
        end_writes();
        hold_len = 400;
        hold_seq++;
        random_words(300, 1);
        phases++;
        drain();

        for (int k = 0; k < 6; k++)
        begin
            random_coefs(k % 2 == 0);
            if (k == 3)
            begin
                hold_len = 300;
                hold_seq++;
            end
            random_words(160, k % 2 == 0);
            drain();
        end

        $display("Covered %0d words in %0d coefficient settings; %0d results checked.",
                 sb.words_in, phases, sb.words_out);
        $display("Saturated temperatures seen: %0d, zero divisors seen: %0d.",
                 sb.sat_seen, sb.dz_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("baro_temp_press_compensation: match");
        else
            $display("baro_temp_press_compensation: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
